@@ rtl/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
// Used by jsu_decode, jsu_burst and json_string_unescape_utf8; no dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int MaxResults = 5;
    localparam int CntW       = $clog2(MaxResults + 1);

    // Characters that steer the token parser.
    localparam logic [7:0] CharQuote  = 8'h22;
    localparam logic [7:0] CharBslash = 8'h5C;
    localparam logic [7:0] CharSlash  = 8'h2F;
    localparam logic [7:0] CharB      = 8'h62;
    localparam logic [7:0] CharF      = 8'h66;
    localparam logic [7:0] CharN      = 8'h6E;
    localparam logic [7:0] CharR      = 8'h72;
    localparam logic [7:0] CharT      = 8'h74;
    localparam logic [7:0] CharU      = 8'h75;
    localparam logic [7:0] CtrlLimit  = 8'h20;

    // Bytes produced by the single-letter escapes.
    localparam logic [7:0] CodeBs = 8'h08;
    localparam logic [7:0] CodeFf = 8'h0C;
    localparam logic [7:0] CodeLf = 8'h0A;
    localparam logic [7:0] CodeCr = 8'h0D;
    localparam logic [7:0] CodeHt = 8'h09;

    // UTF-16 surrogate ranges.
    localparam logic [15:0] SurHighMin = 16'hD800;
    localparam logic [15:0] SurHighMax = 16'hDBFF;
    localparam logic [15:0] SurLowMin  = 16'hDC00;
    localparam logic [15:0] SurLowMax  = 16'hDFFF;
    localparam logic [20:0] SupplBase  = 21'h10000;

    // UTF-8 length limits and lead markers.
    localparam logic [20:0] Utf8Max1 = 21'h00007F;
    localparam logic [20:0] Utf8Max2 = 21'h0007FF;
    localparam logic [20:0] Utf8Max3 = 21'h00FFFF;
    localparam logic [7:0]  Lead2    = 8'hC0;
    localparam logic [7:0]  Lead3    = 8'hE0;
    localparam logic [7:0]  Lead4    = 8'hF0;
    localparam logic [7:0]  ContMark = 8'h80;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_STR     = 8'b0000_0010,
        PH_ESC     = 8'b0000_0100,
        PH_HEX1    = 8'b0000_1000,
        PH_PAIR_BS = 8'b0001_0000,
        PH_PAIR_U  = 8'b0010_0000,
        PH_HEX2    = 8'b0100_0000,
        PH_SKIP    = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NO_QUOTE  = 3'd0,
        ERR_BAD_ESC   = 3'd1,
        ERR_BAD_HEX   = 3'd2,
        ERR_BAD_SUR   = 3'd3,
        ERR_CTRL_BYTE = 3'd4,
        ERR_PREM_END  = 3'd5
    } t_err;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] code;
        logic [7:0] data;
    } t_result;

    typedef struct packed {
        logic [CntW-1:0]              cnt;
        t_result [MaxResults-1:0]     ent;
    } t_burst;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] hex_acc;
        logic [1:0]  hex_cnt;
        logic [15:0] high_sur;
    } t_state;

endpackage

@@ rtl/jsu_decode.sv @@
// Combinational decode of one token byte: next parser state and the burst of results.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_decode (
    input  jsu_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    input  logic            i_eoi,
    output jsu_pkg::t_state o_state,
    output jsu_pkg::t_burst o_burst
);

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                v = c - 8'h30;
                return {1'b1, v[3:0]};
            end
            if (c >= 8'h61 && c <= 8'h66) begin
                v = c - 8'h57;
                return {1'b1, v[3:0]};
            end
            if (c >= 8'h41 && c <= 8'h46) begin
                v = c - 8'h37;
                return {1'b1, v[3:0]};
            end
            return 5'b0;
        end
    endfunction

    logic [4:0]      hex;
    logic [15:0]     acc_new;
    logic            cnt_done;
    logic            emit_cp;
    logic [20:0]     cp;
    logic            single;
    logic [7:0]      single_byte;
    logic            has_term;
    jsu_pkg::t_kind  term_kind;
    logic [2:0]      term_code;
    logic            ended;
    logic            add_end;
    logic [2:0]      ndata;
    logic [7:0]      dat [4];
    logic [2:0]      term_pos;

    assign hex      = hex_value(i_byte);
    assign acc_new  = {i_state.hex_acc[11:0], hex[3:0]};
    assign cnt_done = (i_state.hex_cnt == 2'd3);

    always_comb begin
        o_state     = i_state;
        emit_cp     = 1'b0;
        cp          = '0;
        single      = 1'b0;
        single_byte = '0;
        has_term    = 1'b0;
        term_kind   = jsu_pkg::KIND_DONE;
        term_code   = '0;
        ended       = 1'b0;

        unique case (i_state.phase) inside
            jsu_pkg::PH_IDLE, jsu_pkg::PH_SKIP: begin
                if (i_byte == jsu_pkg::CharQuote) begin
                    o_state.phase = jsu_pkg::PH_STR;
                end else begin
                    ended = 1'b1;
                    if (i_state.phase == jsu_pkg::PH_IDLE) begin
                        has_term      = 1'b1;
                        term_kind     = jsu_pkg::KIND_ERR;
                        term_code     = jsu_pkg::ERR_NO_QUOTE;
                        o_state.phase = jsu_pkg::PH_SKIP;
                    end
                end
            end
            jsu_pkg::PH_STR: begin
                if (i_byte == jsu_pkg::CharQuote) begin
                    has_term      = 1'b1;
                    term_kind     = jsu_pkg::KIND_DONE;
                    ended         = 1'b1;
                    o_state.phase = jsu_pkg::PH_IDLE;
                end else if (i_byte == jsu_pkg::CharBslash) begin
                    o_state.phase = jsu_pkg::PH_ESC;
                end else if (i_byte < jsu_pkg::CtrlLimit) begin
                    has_term      = 1'b1;
                    term_kind     = jsu_pkg::KIND_ERR;
                    term_code     = jsu_pkg::ERR_CTRL_BYTE;
                    ended         = 1'b1;
                    o_state.phase = jsu_pkg::PH_SKIP;
                end else begin
                    single      = 1'b1;
                    single_byte = i_byte;
                end
            end
            jsu_pkg::PH_ESC: begin
                o_state.phase = jsu_pkg::PH_STR;
                case (i_byte) inside
                    jsu_pkg::CharQuote, jsu_pkg::CharBslash, jsu_pkg::CharSlash: begin
                        single      = 1'b1;
                        single_byte = i_byte;
                    end
                    jsu_pkg::CharB: begin
                        single      = 1'b1;
                        single_byte = jsu_pkg::CodeBs;
                    end
                    jsu_pkg::CharF: begin
                        single      = 1'b1;
                        single_byte = jsu_pkg::CodeFf;
                    end
                    jsu_pkg::CharN: begin
                        single      = 1'b1;
                        single_byte = jsu_pkg::CodeLf;
                    end
                    jsu_pkg::CharR: begin
                        single      = 1'b1;
                        single_byte = jsu_pkg::CodeCr;
                    end
                    jsu_pkg::CharT: begin
                        single      = 1'b1;
                        single_byte = jsu_pkg::CodeHt;
                    end
                    jsu_pkg::CharU: begin
                        o_state.hex_acc = '0;
                        o_state.hex_cnt = '0;
                        o_state.phase   = jsu_pkg::PH_HEX1;
                    end
                    default: begin
                        has_term      = 1'b1;
                        term_kind     = jsu_pkg::KIND_ERR;
                        term_code     = jsu_pkg::ERR_BAD_ESC;
                        ended         = 1'b1;
                        o_state.phase = jsu_pkg::PH_SKIP;
                    end
                endcase
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                if (!hex[4]) begin
                    has_term      = 1'b1;
                    term_kind     = jsu_pkg::KIND_ERR;
                    term_code     = jsu_pkg::ERR_BAD_HEX;
                    ended         = 1'b1;
                    o_state.phase = jsu_pkg::PH_SKIP;
                end else begin
                    o_state.hex_acc = acc_new;
                    if (!cnt_done) begin
                        o_state.hex_cnt = 2'(i_state.hex_cnt + 2'd1);
                    end else begin
                        o_state.hex_cnt = '0;
                        if (i_state.phase == jsu_pkg::PH_HEX1) begin
                            if (acc_new >= jsu_pkg::SurHighMin &&
                                acc_new <= jsu_pkg::SurHighMax) begin
                                o_state.high_sur = acc_new;
                                o_state.phase    = jsu_pkg::PH_PAIR_BS;
                            end else if (acc_new >= jsu_pkg::SurLowMin &&
                                         acc_new <= jsu_pkg::SurLowMax) begin
                                has_term      = 1'b1;
                                term_kind     = jsu_pkg::KIND_ERR;
                                term_code     = jsu_pkg::ERR_BAD_SUR;
                                ended         = 1'b1;
                                o_state.phase = jsu_pkg::PH_SKIP;
                            end else begin
                                emit_cp       = 1'b1;
                                cp            = {5'b0, acc_new};
                                o_state.phase = jsu_pkg::PH_STR;
                            end
                        end else begin
                            if (acc_new < jsu_pkg::SurLowMin ||
                                acc_new > jsu_pkg::SurLowMax) begin
                                has_term      = 1'b1;
                                term_kind     = jsu_pkg::KIND_ERR;
                                term_code     = jsu_pkg::ERR_BAD_SUR;
                                ended         = 1'b1;
                                o_state.phase = jsu_pkg::PH_SKIP;
                            end else begin
                                // The offsets from both surrogate bases are just the low ten bits.
                                emit_cp       = 1'b1;
                                cp            = jsu_pkg::SupplBase +
                                                {1'b0, i_state.high_sur[9:0], acc_new[9:0]};
                                o_state.phase = jsu_pkg::PH_STR;
                            end
                        end
                    end
                end
            end
            jsu_pkg::PH_PAIR_BS: begin
                if (i_byte == jsu_pkg::CharBslash) begin
                    o_state.phase = jsu_pkg::PH_PAIR_U;
                end else begin
                    has_term      = 1'b1;
                    term_kind     = jsu_pkg::KIND_ERR;
                    term_code     = jsu_pkg::ERR_BAD_SUR;
                    ended         = 1'b1;
                    o_state.phase = jsu_pkg::PH_SKIP;
                end
            end
            jsu_pkg::PH_PAIR_U: begin
                if (i_byte == jsu_pkg::CharU) begin
                    o_state.hex_acc = '0;
                    o_state.hex_cnt = '0;
                    o_state.phase   = jsu_pkg::PH_HEX2;
                end else begin
                    has_term      = 1'b1;
                    term_kind     = jsu_pkg::KIND_ERR;
                    term_code     = jsu_pkg::ERR_BAD_SUR;
                    ended         = 1'b1;
                    o_state.phase = jsu_pkg::PH_SKIP;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase

        // End of input closes whatever is still open and always returns to idle.
        add_end = i_eoi && !ended;
        if (i_eoi) begin
            o_state.phase = jsu_pkg::PH_IDLE;
        end
    end

    // UTF-8 encoding of a completed code point, or the one plain data byte.
    always_comb begin
        ndata  = '0;
        dat[0] = '0;
        dat[1] = '0;
        dat[2] = '0;
        dat[3] = '0;
        if (single) begin
            ndata  = 3'd1;
            dat[0] = single_byte;
        end else if (emit_cp) begin
            if (cp <= jsu_pkg::Utf8Max1) begin
                ndata  = 3'd1;
                dat[0] = cp[7:0];
            end else if (cp <= jsu_pkg::Utf8Max2) begin
                ndata  = 3'd2;
                dat[0] = jsu_pkg::Lead2 | {3'b0, cp[10:6]};
                dat[1] = jsu_pkg::ContMark | {2'b0, cp[5:0]};
            end else if (cp <= jsu_pkg::Utf8Max3) begin
                ndata  = 3'd3;
                dat[0] = jsu_pkg::Lead3 | {4'b0, cp[15:12]};
                dat[1] = jsu_pkg::ContMark | {2'b0, cp[11:6]};
                dat[2] = jsu_pkg::ContMark | {2'b0, cp[5:0]};
            end else begin
                ndata  = 3'd4;
                dat[0] = jsu_pkg::Lead4 | {5'b0, cp[20:18]};
                dat[1] = jsu_pkg::ContMark | {2'b0, cp[17:12]};
                dat[2] = jsu_pkg::ContMark | {2'b0, cp[11:6]};
                dat[3] = jsu_pkg::ContMark | {2'b0, cp[5:0]};
            end
        end
    end

    assign term_pos = ndata + {2'b0, has_term};

    always_comb begin
        for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
            o_burst.ent[i] = '{kind: jsu_pkg::KIND_DATA, code: 3'd0, data: 8'h00};
            if (3'(i) < ndata) begin
                o_burst.ent[i].data = dat[i % 4];
            end else if (has_term && 3'(i) == ndata) begin
                o_burst.ent[i].kind = term_kind;
                o_burst.ent[i].code = term_code;
            end else if (add_end && 3'(i) == term_pos) begin
                o_burst.ent[i].kind = jsu_pkg::KIND_ERR;
                o_burst.ent[i].code = jsu_pkg::ERR_PREM_END;
            end
        end
        o_burst.cnt = jsu_pkg::CntW'(term_pos + {2'b0, add_end});
    end

endmodule

@@ rtl/jsu_burst.sv @@
// Output stage: holds one byte's results, handing one out per cycle on i_ready.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_burst (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_burst  i_burst,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output jsu_pkg::t_result o_result,
    output logic             o_last
);

    logic [jsu_pkg::CntW-1:0]             r_cnt;
    jsu_pkg::t_result [jsu_pkg::MaxResults-1:0] r_ent;
    logic                                 take;

    assign o_valid    = (r_cnt != '0);
    assign take       = o_valid && i_ready;
    // A new burst may land once the last pending result leaves in this cycle.
    assign o_can_load = (r_cnt == '0) || (r_cnt == jsu_pkg::CntW'(1) && take);
    assign o_result   = r_ent[0];
    assign o_last     = (r_cnt == jsu_pkg::CntW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - jsu_pkg::CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_burst.ent;
        end else if (take) begin
            for (int k = 0; k < jsu_pkg::MaxResults - 1; k++) begin
                r_ent[k] <= r_ent[k + 1];
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= jsu_pkg::CntW'(jsu_pkg::MaxResults))
        else $error("result count out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0 || (r_cnt == jsu_pkg::CntW'(1) && take)))
        else $error("burst loaded over pending results");

    a_code_only_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.kind != jsu_pkg::KIND_ERR) |-> o_result.code == 3'd0)
        else $error("error code set on a non-error result");

    a_byte_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.kind != jsu_pkg::KIND_DATA) |-> o_result.data == 8'h00)
        else $error("data byte set on a done or error result");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_load) |=> r_cnt == $past(r_cnt) - jsu_pkg::CntW'(1))
        else $error("result count did not step down");
`endif

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
// A byte accepted into the input register is decoded from there; its results are loaded
// into the output stage once that stage can take them, and are offered from it.
// Throughput: one byte per cycle while each byte yields at most one result and the output is ready;
// a byte with more results (up to five: UTF-8 burst plus end error) holds input until all are taken.
// Reset (synchronous, active low) returns the parser to idle and empties both registers.
// Top level of the JSON string unescaper; depends on jsu_pkg, jsu_decode and jsu_burst.
`timescale 1ns / 1ps

module json_string_unescape_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] in_byte
    input  logic        i_s_axis_tlast,  // end_of_input
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [7:0] out_byte, [10:8] error_code, [15:11] zero
    output logic [1:0]  o_m_axis_tuser,  // [1:0] out_kind
    output logic        o_m_axis_tlast   // out_last
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eoi;
    jsu_pkg::t_state  r_state;
    jsu_pkg::t_state  n_state;
    jsu_pkg::t_burst  n_burst;
    jsu_pkg::t_result res;
    logic             can_load;
    logic             consume;

    assign consume         = r_in_valid && can_load;
    assign o_s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eoi  <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: jsu_pkg::PH_IDLE, hex_acc: 16'h0, hex_cnt: 2'd0,
                         high_sur: 16'h0};
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    jsu_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_state (n_state),
        .o_burst (n_burst)
    );

    jsu_burst u_burst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (consume),
        .i_burst    (n_burst),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (res),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'b0, res.code, res.data};
    assign o_m_axis_tuser = res.kind;

endmodule
